// ===== design/hkm_pkg.sv =====
// ----------------------------------------------------------------------------
// hkm_pkg
// Shared constants, codes and types of the Hamming k-NN matcher.
// ----------------------------------------------------------------------------
package hkm_pkg;

   localparam int MAX_KNN        = 8;
   localparam int MAX_WORDS      = 8;
   localparam int INDEX_BITS     = 16;
   localparam int DIST_BITS      = 10;
   localparam int WORD_BITS      = 64;
   localparam int CFG_BITS       = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int OP_BITS        = 2;
   localparam int RANK_BITS      = $clog2(MAX_KNN);
   localparam int POS_BITS       = $clog2(MAX_WORDS);
   localparam int POPCNT_BITS    = $clog2(WORD_BITS + 1);
   localparam int RSP_DATA_BITS  = 32;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - DIST_BITS - INDEX_BITS - RANK_BITS;

   localparam logic [DIST_BITS-1:0]  DIST_MAX  = '1;
   localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

   localparam logic [CFG_BITS-1:0] KNN_RESET   = CFG_BITS'(2);
   localparam logic [CFG_BITS-1:0] WORDS_RESET = CFG_BITS'(4);

   typedef enum logic [OP_BITS-1:0] {
      OP_QUERY = 2'd0,
      OP_TRAIN = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_KNN   = 2'd0,
      CSR_WORDS = 2'd1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   // candidate moving down the chain
   typedef struct packed {
      logic                  live;
      logic [DIST_BITS-1:0]  distance;
      logic [INDEX_BITS-1:0] idx;
   } carry_type;

   // one slot of the best list
   typedef struct packed {
      logic                  valid;
      logic [DIST_BITS-1:0]  distance;
      logic [INDEX_BITS-1:0] idx;
   } entry_type;

   // 0 acts as 1, above max acts as max
   function automatic logic [CFG_BITS-1:0] clamp_cfg(input logic [CFG_BITS-1:0] v,
                                                      input int unsigned max);
      logic [CFG_BITS-1:0] res;
      res = v;
      if (v == '0) begin
         res = CFG_BITS'(1);
      end else if (v > CFG_BITS'(max)) begin
         res = CFG_BITS'(max);
      end
      return res;
   endfunction

endpackage

// ===== design/hkm_dist.sv =====
// ----------------------------------------------------------------------------
// hkm_dist
// Query store and per-descriptor Hamming distance accumulator; launches a
// candidate into the cell chain when a train descriptor completes.
// ----------------------------------------------------------------------------
module hkm_dist (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           query_beat,
   input  logic                           train_beat,
   input  logic [hkm_pkg::WORD_BITS-1:0]  data_word,
   input  logic [hkm_pkg::CFG_BITS-1:0]   eff_words,
   output hkm_pkg::carry_type             launch
);
   import hkm_pkg::*;

   logic [WORD_BITS-1:0]  query_ff [MAX_WORDS];
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [DIST_BITS-1:0]  pd_ff, pd_in;
   logic [INDEX_BITS-1:0] cnt_ff, cnt_in;
   carry_type             launch_ff, launch_in;

   logic [POS_BITS:0]     pos_inc;
   logic                  wrap;
   logic [POPCNT_BITS-1:0] ones;
   logic [DIST_BITS:0]    sum;
   logic [DIST_BITS-1:0]  dsat;

   assign pos_inc = {1'b0, pos_ff} + (POS_BITS+1)'(1);
   assign wrap    = (CFG_BITS'(pos_inc) >= eff_words);
   assign ones    = POPCNT_BITS'($countones(data_word ^ query_ff[pos_ff]));
   assign sum     = {1'b0, pd_ff} + (DIST_BITS+1)'(ones);
   assign dsat    = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_BITS-1:0];

   always_comb begin
      pos_in         = pos_ff;
      pd_in          = pd_ff;
      cnt_in         = cnt_ff;
      launch_in      = launch_ff;
      launch_in.live = 1'b0;
      if (query_beat || train_beat) begin
         pos_in = wrap ? '0 : pos_inc[POS_BITS-1:0];
      end
      if (query_beat) begin
         pd_in  = '0;
         cnt_in = '0;
      end else if (train_beat) begin
         if (wrap) begin
            launch_in.live     = 1'b1;
            launch_in.distance = dsat;
            launch_in.idx      = cnt_ff;
            pd_in              = '0;
            if (cnt_ff != INDEX_MAX) begin
               cnt_in = cnt_ff + INDEX_BITS'(1);
            end
         end else begin
            pd_in = dsat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (query_beat) begin
         query_ff[pos_ff] <= data_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         pd_ff          <= '0;
         cnt_ff         <= '0;
         launch_ff.live <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         pd_ff          <= pd_in;
         cnt_ff         <= cnt_in;
         launch_ff.live <= launch_in.live;
      end
   end

   always_ff @(posedge clock) begin
      launch_ff.distance <= launch_in.distance;
      launch_ff.idx      <= launch_in.idx;
   end

   assign launch = launch_ff;

endmodule

// ===== design/hkm_cell.sv =====
// ----------------------------------------------------------------------------
// hkm_cell
// One slot of the sorted best list. Swaps with a passing candidate when the
// slot is empty or strictly farther, and hands the loser to the next cell.
// ----------------------------------------------------------------------------
module hkm_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                enable,
   input  hkm_pkg::carry_type  carry_in,
   output hkm_pkg::carry_type  carry_out,
   output hkm_pkg::entry_type  entry
);
   import hkm_pkg::*;

   entry_type entry_ff, entry_in;
   carry_type carry_ff, carry_in_nxt;
   logic      take;

   assign take = carry_in.live && enable &&
                 (!entry_ff.valid || (carry_in.distance < entry_ff.distance));

   always_comb begin
      entry_in          = entry_ff;
      carry_in_nxt      = carry_in;
      carry_in_nxt.live = carry_in.live && enable;
      if (take) begin
         entry_in.valid        = 1'b1;
         entry_in.distance     = carry_in.distance;
         entry_in.idx          = carry_in.idx;
         carry_in_nxt.live     = entry_ff.valid;
         carry_in_nxt.distance = entry_ff.distance;
         carry_in_nxt.idx      = entry_ff.idx;
      end
      if (clear) begin
         entry_in.valid    = 1'b0;
         carry_in_nxt.live = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         carry_ff.live  <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
         carry_ff.live  <= carry_in_nxt.live;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.distance <= entry_in.distance;
      entry_ff.idx      <= entry_in.idx;
      carry_ff.distance <= carry_in_nxt.distance;
      carry_ff.idx      <= carry_in_nxt.idx;
   end

   assign carry_out = carry_ff;
   assign entry     = entry_ff;

endmodule

// ===== design/hamming_knn_matcher.sv =====
// ----------------------------------------------------------------------------
// hamming_knn_matcher
// Brute-force Hamming k-nearest-neighbor matcher, one query at a time.
// ----------------------------------------------------------------------------
// Usage: send the query descriptor as desc_words beats with opcode 0 (this
// clears the best list and the train index), then stream train descriptor
// words with opcode 1, then one opcode 2 beat to read the list out as knn
// beats in rank order, tlast on the final one. Query and train words are
// taken one per cycle while no read-out is in progress. Each finished
// descriptor's candidate walks the chain of MAX_KNN cells one cell per cycle,
// pipelined behind earlier ones; a read-out request (and any CSR write) is
// held off until the chain has drained, and then yields one result beat per
// cycle, paced by rsp_tready. Ties keep the earlier train descriptor; empty
// slots come out with valid_res 0 and zero distance and index. The train
// index saturates at its maximum. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module hamming_knn_matcher (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hkm_pkg::WORD_BITS-1:0]       req_tdata,  // [63:0] data_word
   input  logic [hkm_pkg::OP_BITS-1:0]         req_tuser,  // [1:0] opcode
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hkm_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // [9:0] distance,
                                                           // [25:10] train_index,
                                                           // [28:26] rank, rest 0
   output logic                                rsp_tuser,  // [0] valid_res
   output logic                                rsp_tlast,  // last beat of read-out
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hkm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [hkm_pkg::CFG_BITS-1:0]        csr_data
);
   import hkm_pkg::*;

   // ---------------- configuration ----------------
   logic [CFG_BITS-1:0] knn_ff, words_ff;
   logic [CFG_BITS-1:0] eff_knn, eff_words;
   logic                csr_beat;

   assign eff_knn   = clamp_cfg(knn_ff, MAX_KNN);
   assign eff_words = clamp_cfg(words_ff, MAX_WORDS);

   // ---------------- request decode ----------------
   state_type state_ff, state_in;
   logic      req_beat, query_beat, train_beat, read_beat;
   logic      busy;  // a candidate is still moving through the chain

   assign req_tready = (state_ff == ST_IDLE) && !(busy && (req_tuser == OP_READ));
   assign req_beat   = req_tvalid && req_tready;
   assign query_beat = req_beat && (req_tuser == OP_QUERY);
   assign train_beat = req_beat && (req_tuser == OP_TRAIN);
   assign read_beat  = req_beat && (req_tuser == OP_READ);

   // CSR writes only while nothing is in flight
   assign csr_ready = (state_ff == ST_IDLE) && !busy;
   assign csr_beat  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         knn_ff   <= KNN_RESET;
         words_ff <= WORDS_RESET;
      end else if (csr_beat) begin
         case (csr_index)
            CSR_KNN:   knn_ff   <= csr_data;
            CSR_WORDS: words_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- distance unit ----------------
   carry_type carry [MAX_KNN+1];
   entry_type entries [MAX_KNN];
   logic [MAX_KNN:0] live_vec;

   hkm_dist u_dist (
      .clock      (clock),
      .reset      (reset),
      .query_beat (query_beat),
      .train_beat (train_beat),
      .data_word  (req_tdata),
      .eff_words  (eff_words),
      .launch     (carry[0])
   );

   // ---------------- cell chain ----------------
   genvar k;
   generate
      for (k = 0; k < MAX_KNN; k++) begin : g_cell
         hkm_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .clear     (query_beat),
            .enable    (CFG_BITS'(k) < eff_knn),
            .carry_in  (carry[k]),
            .carry_out (carry[k+1]),
            .entry     (entries[k])
         );
      end
      for (k = 0; k <= MAX_KNN; k++) begin : g_live
         assign live_vec[k] = carry[k].live;
      end
   endgenerate

   assign busy = |live_vec;

   // ---------------- read-out sequencer ----------------
   logic [RANK_BITS-1:0] rd_ff, rd_in;
   logic                 out_free, load_beat, rd_last;
   entry_type            rd_entry;

   assign out_free = !rsp_tvalid || rsp_tready;
   assign rd_entry = entries[rd_ff];
   assign rd_last  = ((CFG_BITS'(rd_ff) + CFG_BITS'(1)) == eff_knn);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (read_beat) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (out_free && rd_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      load_beat = 1'b0;
      rd_in     = rd_ff;
      case (state_ff)
         ST_IDLE: begin
            rd_in = '0;
         end
         ST_READ: begin
            load_beat = out_free;
            if (out_free) begin
               rd_in = rd_ff + RANK_BITS'(1);
            end
         end
         default: rd_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rd_ff    <= '0;
      end else begin
         state_ff <= state_in;
         rd_ff    <= rd_in;
      end
   end

   // ---------------- output register ----------------
   logic                     rsp_valid_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                     rsp_user_ff, rsp_last_ff;

   assign rsp_data_in = {{RSP_PAD_BITS{1'b0}}, rd_ff,
                         rd_entry.valid ? rd_entry.idx      : {INDEX_BITS{1'b0}},
                         rd_entry.valid ? rd_entry.distance : {DIST_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_beat) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_beat) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rd_entry.valid;
         rsp_last_ff <= rd_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
